FILE: design/blprd_pkg.sv
// Package for the button long-press / auto-repeat detector.
// Types, codes, reset values and slot decode helpers; no dependencies.
package blprd_pkg;

  // Sizes
  localparam int NumButtons     = 2;
  localparam int ButtonW        = 1;
  localparam int LevelW         = 2;
  localparam int CountW         = 8;
  localparam int KindsPerButton = 3;
  localparam int NumSlots       = NumButtons * KindsPerButton;
  localparam int SlotW          = $clog2(NumSlots);
  localparam int MaxEvents      = 4;
  localparam int EvCntW         = $clog2(MaxEvents);
  localparam int QueueDepth     = 2;
  localparam int QPtrW          = $clog2(QueueDepth);
  localparam int QCntW          = $clog2(QueueDepth + 1);

  // Register reset values
  localparam logic [CountW-1:0] LongThresholdReset = 8'd9;
  localparam logic [CountW-1:0] RepeatCapReset     = 8'd16;

  // Input command codes
  typedef enum logic {
    CmdDown = 1'b0,
    CmdTick = 1'b1
  } command_e;

  // Configuration register indexes
  typedef enum logic {
    CfgLongThreshold = 1'b0,
    CfgRepeatCap     = 1'b1
  } cfg_index_e;

  // Event kinds
  typedef enum logic [1:0] {
    KindLong    = 2'd0,
    KindRepeat  = 2'd1,
    KindRelease = 2'd2
  } event_kind_e;

  // One tick's worth of events: bit (button * 3 + kind) set per event,
  // ordered so that the lowest set bit is the next event to deliver.
  typedef struct packed {
    logic                valid;
    logic [NumSlots-1:0] mask;
  } tick_item_t;

  // Button of an event slot
  function automatic logic [ButtonW-1:0] slot_button(logic [SlotW-1:0] slot);
    logic [ButtonW-1:0] b_out;
    b_out = '0;
    for (int b = 0; b < NumButtons; b++) begin
      for (int k = 0; k < KindsPerButton; k++) begin
        if (slot == SlotW'(b * KindsPerButton + k)) b_out = ButtonW'(b);
      end
    end
    return b_out;
  endfunction

  // Kind of an event slot
  function automatic event_kind_e slot_kind(logic [SlotW-1:0] slot);
    event_kind_e k_out;
    k_out = KindLong;
    for (int b = 0; b < NumButtons; b++) begin
      for (int k = 0; k < KindsPerButton; k++) begin
        if (slot == SlotW'(b * KindsPerButton + k)) k_out = event_kind_e'(2'(k));
      end
    end
    return k_out;
  endfunction

endpackage

FILE: design/button_long_press_repeat_detector_core.sv
// Top level of the button long-press / auto-repeat detector.
// Instantiates blprd_front, blprd_queue and blprd_back; uses blprd_pkg.
//
// A down item produces nothing. A tick item's events (long, repeat, release
// per active button, lowest button first, at most four) pass through the
// queue and the back-end mask register into the output register, which
// they leave one per cycle unless the receiver stalls. The back-end
// sequencer loads each mask as a step of its own and takes no new one
// until its last event is sent; a two-entry queue lets the front keep
// taking items while earlier events drain. Register writes are always ready.
module button_long_press_repeat_detector_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic [blprd_pkg::ButtonW-1:0] button_index_i,
  input  logic [blprd_pkg::LevelW-1:0]  release_levels_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [blprd_pkg::CountW-1:0]  cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [blprd_pkg::ButtonW-1:0] event_button_o,
  output logic [1:0]                    event_kind_o,
  output logic                          last_event_o
);

  blprd_pkg::tick_item_t push, head;
  logic                  q_full, pop;

  blprd_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .command_i,
    .button_index_i,
    .release_levels_i,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .q_full_i (q_full),
    .push_o   (push)
  );

  blprd_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  blprd_back u_back (
    .clk_i,
    .rst_ni,
    .head_i (head),
    .pop_o  (pop),
    .out_valid_o,
    .out_stall_i,
    .event_button_o,
    .event_kind_o,
    .last_event_o
  );

endmodule

FILE: design/blprd_front.sv
// Front end: accepts items, holds button state and config registers,
// and turns each tick into an event mask. Uses blprd_pkg.
module blprd_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            command_i,
  input  logic [blprd_pkg::ButtonW-1:0]   button_index_i,
  input  logic [blprd_pkg::LevelW-1:0]    release_levels_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_index_i,
  input  logic [blprd_pkg::CountW-1:0]    cfg_data_i,
  input  logic                            q_full_i,
  output blprd_pkg::tick_item_t           push_o
);

  logic [blprd_pkg::CountW-1:0]     long_thr_q, repeat_cap_q;
  logic [blprd_pkg::NumButtons-1:0] active_q, active_d;
  logic [blprd_pkg::CountW-1:0]     hold_q [blprd_pkg::NumButtons];
  logic [blprd_pkg::CountW-1:0]     hold_d [blprd_pkg::NumButtons];
  logic [blprd_pkg::NumSlots-1:0]   mask;
  logic [blprd_pkg::CountW:0]       next_cnt [blprd_pkg::NumButtons];
  logic                             accept;

  assign in_stall_o  = q_full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_thr_q   <= blprd_pkg::LongThresholdReset;
      repeat_cap_q <= blprd_pkg::RepeatCapReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (blprd_pkg::cfg_index_e'(cfg_index_i))
        blprd_pkg::CfgLongThreshold: long_thr_q   <= cfg_data_i;
        blprd_pkg::CfgRepeatCap:     repeat_cap_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Per-button update: count one bit wider so a cap of 255 never wraps
  always_comb begin
    active_d = active_q;
    mask     = '0;
    for (int i = 0; i < blprd_pkg::NumButtons; i++) begin
      hold_d[i]   = hold_q[i];
      next_cnt[i] = {1'b0, hold_q[i]} + 1'b1;
    end
    if (accept) begin
      if (command_i == blprd_pkg::CmdDown) begin
        if (int'(button_index_i) < blprd_pkg::NumButtons) active_d[button_index_i] = 1'b1;
      end else begin
        for (int i = 0; i < blprd_pkg::NumButtons; i++) begin
          if (active_q[i]) begin
            hold_d[i] = next_cnt[i][blprd_pkg::CountW-1:0];
            if (next_cnt[i] == {1'b0, long_thr_q})
              mask[i * blprd_pkg::KindsPerButton + int'(blprd_pkg::KindLong)] = 1'b1;
            if (next_cnt[i] > {1'b0, repeat_cap_q}) begin
              hold_d[i] = repeat_cap_q;
              mask[i * blprd_pkg::KindsPerButton + int'(blprd_pkg::KindRepeat)] = 1'b1;
            end
            if (release_levels_i[i]) begin
              hold_d[i]   = '0;
              active_d[i] = 1'b0;
              mask[i * blprd_pkg::KindsPerButton + int'(blprd_pkg::KindRelease)] = 1'b1;
            end
          end
        end
      end
    end
  end

  // Only ticks that raise events go into the queue
  assign push_o.valid = accept && (command_i == blprd_pkg::CmdTick) && (|mask);
  assign push_o.mask  = mask;

  // Button state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      for (int i = 0; i < blprd_pkg::NumButtons; i++) hold_q[i] <= '0;
    end else begin
      active_q <= active_d;
      for (int i = 0; i < blprd_pkg::NumButtons; i++) hold_q[i] <= hold_d[i];
    end
  end

endmodule

FILE: design/blprd_queue.sv
// Short queue of tick event masks between front and back end.
// Uses blprd_pkg.
module blprd_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  blprd_pkg::tick_item_t push_i,
  output logic                  full_o,
  output blprd_pkg::tick_item_t head_o,
  input  logic                  pop_i
);

  logic [blprd_pkg::NumSlots-1:0] mem_q [blprd_pkg::QueueDepth];
  logic [blprd_pkg::QPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [blprd_pkg::QCntW-1:0]    cnt_q;
  logic                           do_pop;

  assign full_o       = (cnt_q == blprd_pkg::QCntW'(blprd_pkg::QueueDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.mask  = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_o.valid;

  // Payload storage
  always_ff @(posedge clk_i) begin
    if (push_i.valid) mem_q[wr_ptr_q] <= push_i.mask;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i.valid) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)       rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i.valid && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i.valid && do_pop) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

FILE: design/blprd_back.sv
// Back end: pulls one event mask at a time and sends its events, lowest
// slot first and at most four, through the output register. Uses blprd_pkg.
module blprd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  blprd_pkg::tick_item_t         head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [blprd_pkg::ButtonW-1:0] event_button_o,
  output logic [1:0]                    event_kind_o,
  output logic                          last_event_o
);

  logic [blprd_pkg::NumSlots-1:0] cur_q, cur_d, sel_hot, rest;
  logic [blprd_pkg::EvCntW-1:0]   cnt_q, cnt_d;
  logic [blprd_pkg::SlotW-1:0]    sel;
  logic                           has, load_out, emit, last;
  logic                           out_valid_q, out_valid_d;
  logic [blprd_pkg::ButtonW-1:0]  button_q;
  blprd_pkg::event_kind_e         kind_q;
  logic                           last_q;

  // Lowest pending slot
  always_comb begin
    sel     = '0;
    sel_hot = '0;
    for (int s = blprd_pkg::NumSlots - 1; s >= 0; s--) begin
      if (cur_q[s]) begin
        sel     = blprd_pkg::SlotW'(s);
        sel_hot = blprd_pkg::NumSlots'(1) << s;
      end
    end
  end

  assign has      = |cur_q;
  assign rest     = cur_q & ~sel_hot;
  assign load_out = !out_valid_q || !out_stall_i;
  assign emit     = has && load_out;
  assign last     = (cnt_q == blprd_pkg::EvCntW'(blprd_pkg::MaxEvents - 1)) || (rest == '0);
  assign pop_o    = head_i.valid && !has;

  // Sequencer next state
  always_comb begin
    cur_d = cur_q;
    cnt_d = cnt_q;
    if (pop_o) begin
      cur_d = head_i.mask;
      cnt_d = '0;
    end else if (emit) begin
      cur_d = last ? '0 : rest;
      cnt_d = cnt_q + 1'b1;
    end
    out_valid_d = emit ? 1'b1 : (load_out ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_q       <= cur_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      button_q <= blprd_pkg::slot_button(sel);
      kind_q   <= blprd_pkg::slot_kind(sel);
      last_q   <= last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_button_o = button_q;
  assign event_kind_o   = kind_q;
  assign last_event_o   = last_q;

endmodule

FILE: design/blprd_checker.sv
// Port-level checker for the detector, bound to the top level.
// Uses blprd_pkg.
module blprd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [blprd_pkg::ButtonW-1:0] event_button_o,
  input logic [1:0]                    event_kind_o,
  input logic                          last_event_o
);

  logic                         out_acc;
  logic [blprd_pkg::EvCntW-1:0] run_q;

  assign out_acc = out_valid_o && !out_stall_i;

  // Events delivered since the last one marked last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else if (out_acc) begin
      run_q <= last_event_o ? '0 : run_q + 1'b1;
    end
  end

  // A stalled item stays
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped under stall");

  // A stalled item keeps its fields
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(event_button_o) && $stable(event_kind_o)
      && $stable(last_event_o))
    else $error("output item changed under stall");

  // No more than four events per tick
  a_max_events: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && (run_q == blprd_pkg::EvCntW'(blprd_pkg::MaxEvents - 1)) |-> last_event_o)
    else $error("tick produced more than four events");

  // Events of one tick leave back to back
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !last_event_o |=> out_valid_o)
    else $error("gap inside the events of one tick");

endmodule

bind button_long_press_repeat_detector_core blprd_checker u_blprd_checker (
  .clk_i,
  .rst_ni,
  .out_valid_o,
  .out_stall_i,
  .event_button_o,
  .event_kind_o,
  .last_event_o
);

FILE: tb/press_event_checker.sv
// Event checker for the button long-press / auto-repeat detector.
// Watches the item, register and event channels, predicts events; uses blprd_pkg.
`timescale 1ns / 100ps

module press_event_checker
  import blprd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               command_i,
  input  logic [ButtonW-1:0] button_index_i,
  input  logic [LevelW-1:0]  release_levels_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic               cfg_index_i,
  input  logic [CountW-1:0]  cfg_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [ButtonW-1:0] event_button_i,
  input  logic [1:0]         event_kind_i,
  input  logic               last_event_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 events_checked_o
);

  typedef struct packed {
    logic [ButtonW-1:0] button;
    event_kind_e        kind;
    logic               last;
  } press_event_t;

  // Events still owed by the block, oldest first
  press_event_t expected_events[$];

  // Shadow of the block's button state and registers
  logic [NumButtons-1:0] held_mask;
  logic [CountW-1:0]     hold_cnt [NumButtons];
  logic [CountW-1:0]     long_thr;
  logic [CountW-1:0]     rep_cap;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    fail_count_o++;
  endtask

  // Advance every held button by one tick and queue the events it raises
  task automatic predict_tick(input logic [LevelW-1:0] levels);
    press_event_t    tick_events[$];
    logic [CountW:0] nxt;
    for (int b = 0; b < NumButtons; b++) begin
      if (!held_mask[b]) continue;
      // one bit wider, so a cap of 255 still clamps instead of wrapping
      nxt = {1'b0, hold_cnt[b]} + 1'b1;
      if (nxt == {1'b0, long_thr}) tick_events.push_back('{ButtonW'(b), KindLong, 1'b0});
      if (nxt > {1'b0, rep_cap}) begin
        nxt = {1'b0, rep_cap};
        tick_events.push_back('{ButtonW'(b), KindRepeat, 1'b0});
      end
      hold_cnt[b] = nxt[CountW-1:0];
      if (levels[b]) begin
        held_mask[b] = 1'b0;
        hold_cnt[b]  = '0;
        tick_events.push_back('{ButtonW'(b), KindRelease, 1'b0});
      end
    end
    // only the first few events of a tick are delivered; state moves regardless
    while (tick_events.size() > MaxEvents) void'(tick_events.pop_back());
    if (tick_events.size() > 0) tick_events[tick_events.size()-1].last = 1'b1;
    foreach (tick_events[i]) expected_events.push_back(tick_events[i]);
  endtask

  // Compare one delivered event against the oldest expectation
  task automatic check_event();
    press_event_t want;
    if (expected_events.size() == 0) begin
      report_mismatch($sformatf("unexpected event button %0d kind %0d last %0d",
                                event_button_i, event_kind_i, last_event_i));
    end else begin
      want = expected_events.pop_front();
      if (event_button_i !== want.button)
        report_mismatch($sformatf("event_button got %0d want %0d", event_button_i,
                                  want.button));
      if (event_kind_i !== want.kind)
        report_mismatch($sformatf("event_kind got %0d want %0d (button %0d)",
                                  event_kind_i, want.kind, want.button));
      if (last_event_i !== want.last)
        report_mismatch($sformatf("last_event got %0d want %0d (button %0d kind %0d)",
                                  last_event_i, want.last, want.button, want.kind));
    end
    events_checked_o++;
  endtask

  // Sample all channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_mask = '0;
      for (int b = 0; b < NumButtons; b++) hold_cnt[b] = '0;
      long_thr = LongThresholdReset;
      rep_cap  = RepeatCapReset;
      expected_events.delete();
      fail_count_o     = 0;
      events_checked_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_e'(cfg_index_i))
          CfgLongThreshold: long_thr = cfg_data_i;
          CfgRepeatCap:     rep_cap  = cfg_data_i;
          default:          ;
        endcase
      end
      if (out_valid_i && !out_stall_i) check_event();
      if (in_valid_i && !in_stall_i) begin
        if (command_e'(command_i) == CmdTick) begin
          predict_tick(release_levels_i);
        end else if (int'(button_index_i) < NumButtons) begin
          held_mask[button_index_i] = 1'b1;
        end
      end
    end
    pending_o = expected_events.size();
  end

endmodule

FILE: tb/button_long_press_repeat_detector_core_tb.sv
// Testbench top for button_long_press_repeat_detector_core.
// Drives items, register writes and output stalls; checking is in press_event_checker.
`timescale 1ns / 100ps

module button_long_press_repeat_detector_core_tb;
  import blprd_pkg::*;

  localparam int ClkHalf        = 10;
  localparam int ResetCycles    = 2;
  localparam int SettleCycles   = 12;   // covers a tick that raises no event
  localparam int LongHoldCycles = 120;
  localparam int IdleLimit      = 2000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               command_i;
  logic [ButtonW-1:0] button_index_i;
  logic [LevelW-1:0]  release_levels_i;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic               cfg_index_i;
  logic [CountW-1:0]  cfg_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [ButtonW-1:0] event_button_o;
  logic [1:0]         event_kind_o;
  logic               last_event_o;

  int chk_fail_count;
  int chk_pending;
  int chk_events;

  int items_sent    = 0;
  int ticks_sent    = 0;
  int reg_writes    = 0;
  int settings_used = 1;
  int burst_left    = 0;
  int hold_requests = 0;
  int idle_cycles   = 0;

  button_long_press_repeat_detector_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .button_index_i  (button_index_i),
    .release_levels_i(release_levels_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_button_o  (event_button_o),
    .event_kind_o    (event_kind_o),
    .last_event_o    (last_event_o)
  );

  press_event_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .command_i       (command_i),
    .button_index_i  (button_index_i),
    .release_levels_i(release_levels_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_button_i  (event_button_o),
    .event_kind_i    (event_kind_o),
    .last_event_i    (last_event_o),
    .fail_count_o    (chk_fail_count),
    .pending_o       (chk_pending),
    .events_checked_o(chk_events)
  );

  // Clock
  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // Watchdog: ends the run when no channel moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no handshake for %0d cycles, %0d events outstanding",
               idle_cycles, chk_pending);
      $display("status: fail");
      $finish;
    end
  end

  // Receiver stalls: random stretches, plus a long hold-off on request
  initial begin : rx_stall_pattern
    int holds_served;
    int stretch_left;
    int stall_pct;
    holds_served = 0;
    stretch_left = 0;
    stall_pct    = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_served) begin
        holds_served++;
        out_stall_i <= 1'b1;
        repeat (LongHoldCycles - 1) @(posedge clk_i);
      end else begin
        if (stretch_left == 0) begin
          stretch_left = $urandom_range(10, 60);
          case ($urandom_range(0, 2))
            0:       stall_pct = 0;
            1:       stall_pct = 40;
            default: stall_pct = 80;
          endcase
        end
        stretch_left--;
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Offer one item and wait for it to be taken; gaps fall between bursts
  task automatic send_item(input command_e cmd, input logic [ButtonW-1:0] idx,
                           input logic [LevelW-1:0] levels);
    in_valid_i       <= 1'b1;
    command_i        <= cmd;
    button_index_i   <= idx;
    release_levels_i <= levels;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    if (cmd == CmdTick) ticks_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                                : $urandom_range(0, 8);
    end
  endtask

  // Stop offering items and let every owed event come out
  task automatic quiesce();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (chk_pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [CountW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    reg_writes++;
  endtask

  task automatic apply_setting(input logic [CountW-1:0] thr, input logic [CountW-1:0] cap);
    quiesce();
    write_reg(CfgLongThreshold, thr);
    write_reg(CfgRepeatCap, cap);
    settings_used++;
  endtask

  // Mostly presses and ticks with random releases; some stray items.
  // With spare_b0 set, button 0 is never released so its count saturates.
  task automatic run_random_phase(input int tick_goal, input int tick_pct,
                                  input bit spare_b0);
    int                 phase_ticks;
    int                 n_done;
    int                 r;
    command_e           cmd;
    logic [ButtonW-1:0] idx;
    logic [LevelW-1:0]  levels;
    phase_ticks = 0;
    n_done      = 0;
    if (spare_b0) send_item(CmdDown, 1'b0, LevelW'($urandom_range(0, 3)));
    while (phase_ticks < tick_goal) begin
      r      = $urandom_range(0, 99);
      idx    = ButtonW'($urandom_range(0, 1));
      levels = LevelW'($urandom_range(0, 3));
      if (r < tick_pct) begin
        cmd = CmdTick;
        if ($urandom_range(0, 3) != 0) levels = '0;
      end else if (r < 95) begin
        cmd = CmdDown;
      end else begin
        cmd = command_e'($urandom_range(0, 1));
      end
      if (spare_b0) levels[0] = 1'b0;
      if (cmd == CmdTick) phase_ticks++;
      send_item(cmd, idx, levels);
      n_done++;
      // long receiver hold-off while buttons are held and ticks keep coming
      if (n_done == 4) hold_requests++;
    end
  endtask

  // Stimulus and verdict
  initial begin
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    command_i        <= CmdDown;
    button_index_i   <= '0;
    release_levels_i <= '0;
    cfg_valid_i      <= 1'b0;
    cfg_index_i      <= CfgLongThreshold;
    cfg_data_i       <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers: idle tick, duplicate press, release of one button
    send_item(CmdTick, 1'b1, 2'b11);
    send_item(CmdDown, 1'b0, 2'b01);
    send_item(CmdDown, 1'b0, 2'b10);
    send_item(CmdDown, 1'b1, 2'b11);
    send_item(CmdTick, 1'b0, 2'b00);
    send_item(CmdTick, 1'b1, 2'b10);

    // Threshold one above the cap: long and repeat together, then a tick
    // with more events than the block delivers
    apply_setting(8'd4, 8'd3);
    send_item(CmdDown, 1'b1, 2'b00);
    send_item(CmdTick, 1'b0, 2'b00);
    send_item(CmdTick, 1'b0, 2'b00);
    send_item(CmdTick, 1'b0, 2'b00);
    send_item(CmdTick, 1'b0, 2'b11);

    // Zero threshold never fires; zero cap repeats on every tick
    apply_setting(8'd0, 8'd0);
    send_item(CmdDown, 1'b0, 2'b00);
    send_item(CmdDown, 1'b1, 2'b00);
    send_item(CmdTick, 1'b0, 2'b00);
    send_item(CmdTick, 1'b1, 2'b01);
    send_item(CmdTick, 1'b0, 2'b10);

    // Largest cap: button 0 climbs to 255 and stays there
    apply_setting(8'd255, 8'd255);
    run_random_phase(262, 85, 1'b1);

    // Cap dropped under a held count, then assorted settings
    apply_setting(8'd6, 8'd5);
    run_random_phase(18, 60, 1'b0);
    apply_setting(8'd1, 8'd1);
    run_random_phase(18, 60, 1'b0);
    apply_setting(8'd255, 8'd0);
    run_random_phase(18, 60, 1'b0);
    apply_setting(CountW'($urandom_range(1, 12)), CountW'($urandom_range(1, 12)));
    run_random_phase(18, 60, 1'b0);

    quiesce();
    $display("covered %0d items (%0d ticks), %0d events checked", items_sent, ticks_sent,
             chk_events);
    $display("%0d register writes over %0d settings, %0d receiver hold-offs", reg_writes,
             settings_used, hold_requests);
    if (chk_pending != 0) $display("%0d expected events never delivered", chk_pending);
    if (chk_fail_count == 0 && chk_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
